// File: sv/afzc_pkg.sv
package afzc_pkg;

  // Bit clock ticks per bit period (legal range 2..15).
  localparam int TicksPerBit = 8;

  localparam int CdW = 4;
  localparam int ShiftReloadRaw = TicksPerBit + TicksPerBit / 2;
  localparam int ShiftReloadSat = (ShiftReloadRaw > 15) ? 15 : ShiftReloadRaw;

  localparam logic [CdW-1:0] CD_BIT    = CdW'(TicksPerBit);
  localparam logic [CdW-1:0] CD_SHIFT  = CdW'(ShiftReloadSat);

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] TALLY_LIMIT = 8'd250;
  localparam logic [7:0] TALLY_FULL  = 8'd8;
  localparam logic [2:0] STUFF_RUN   = 3'd5;
  localparam logic [2:0] ONES_MAX    = 3'd7;

  // Carrier tone codes
  localparam logic [1:0] TONE_NONE = 2'd0;
  localparam logic [1:0] TONE_1200 = 2'd1;
  localparam logic [1:0] TONE_2200 = 2'd2;

  // Operation codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_BAND_HIGH_MIN = 3'd0;
  localparam logic [2:0] REG_BAND_HIGH_MAX = 3'd1;
  localparam logic [2:0] REG_BAND_LOW_MIN  = 3'd2;
  localparam logic [2:0] REG_BAND_LOW_MAX  = 3'd3;
  localparam logic [2:0] REG_CARRIER_HOLD  = 3'd4;

  localparam logic [15:0] RST_BAND_HIGH_MIN = 16'd800;
  localparam logic [15:0] RST_BAND_HIGH_MAX = 16'd877;
  localparam logic [15:0] RST_BAND_LOW_MIN  = 16'd1417;
  localparam logic [15:0] RST_BAND_LOW_MAX  = 16'd1675;
  localparam logic [7:0]  RST_CARRIER_HOLD  = 8'd64;

  typedef struct packed {
    logic        operation;
    logic [15:0] edge_period;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [1:0] carrier_tone;
  } out_item_t;

  typedef struct packed {
    logic [15:0] band_high_min;
    logic [15:0] band_high_max;
    logic [15:0] band_low_min;
    logic [15:0] band_low_max;
    logic [7:0]  carrier_hold;
  } cfg_t;

  // Classified item passed from front to back. tone == TONE_NONE on an
  // edge means the period fell outside both bands.
  typedef struct packed {
    logic       is_tick;
    logic [1:0] tone;
  } cmd_t;

endpackage

// File: sv/afzc_front.sv
module afzc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  afzc_pkg::cfg_t     cfg,
  input  logic               push,
  output logic               full,
  input  afzc_pkg::in_item_t item,
  output logic               cmd_avail,
  input  logic               cmd_take,
  output afzc_pkg::cmd_t     cmd
);

  afzc_pkg::cmd_t cls;
  afzc_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push, do_pop;

  // Band classification; the 1200 Hz band wins on overlap.
  always_comb begin
    cls.is_tick = (item.operation == afzc_pkg::OP_TICK);
    if (item.edge_period > cfg.band_low_min && item.edge_period < cfg.band_low_max) begin
      cls.tone = afzc_pkg::TONE_1200;
    end else if (item.edge_period > cfg.band_high_min &&
                 item.edge_period < cfg.band_high_max) begin
      cls.tone = afzc_pkg::TONE_2200;
    end else begin
      cls.tone = afzc_pkg::TONE_NONE;
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_avail = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_avail;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("cmd queue count overflow");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("cmd queue pointers disagree with count");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !cmd_take) |=> full) else $error("cmd queue lost an entry");

endmodule

// File: sv/afzc_back.sv
module afzc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          carrier_hold,
  input  logic                cmd_avail,
  output logic                cmd_take,
  input  afzc_pkg::cmd_t      cmd,
  output logic                res_empty,
  input  logic                res_pop,
  output afzc_pkg::out_item_t res
);

  logic [1:0]               tone_r, tone_nxt;
  logic                     shift_seen_r, shift_seen_nxt;
  logic [7:0]               hold_r, hold_nxt;
  logic [7:0]               sbyte_r, sbyte_nxt;
  logic [7:0]               tally_r, tally_nxt;
  logic [2:0]               ones_r, ones_nxt;
  logic [afzc_pkg::CdW-1:0] cd_r, cd_nxt;
  logic                     synced_r, synced_nxt;
  logic                     shifted, emit;

  afzc_pkg::out_item_t q_r [2];
  afzc_pkg::out_item_t res_item;
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          cnt_r;
  logic                res_full, do_pop;

  assign res_full  = (cnt_r == 2'd2);
  assign res_empty = (cnt_r == 2'd0);
  assign cmd_take  = cmd_avail && !res_full;
  assign do_pop    = res_pop && !res_empty;
  assign res       = q_r[rd_ptr_r];

  always_comb begin
    tone_nxt       = tone_r;
    shift_seen_nxt = shift_seen_r;
    hold_nxt       = hold_r;
    sbyte_nxt      = sbyte_r;
    tally_nxt      = tally_r;
    ones_nxt       = ones_r;
    cd_nxt         = cd_r;
    synced_nxt     = synced_r;
    shifted        = 1'b0;
    emit           = 1'b0;

    if (!cmd.is_tick) begin
      if (cmd.tone != afzc_pkg::TONE_NONE) begin
        if (tone_r != cmd.tone) begin
          shift_seen_nxt = 1'b1;
        end
        tone_nxt = cmd.tone;
        hold_nxt = carrier_hold;
      end else if (hold_r != 8'd0) begin
        hold_nxt = hold_r - 8'd1;
      end else begin
        tone_nxt = afzc_pkg::TONE_NONE;
      end
    end else if (tone_r == afzc_pkg::TONE_NONE) begin
      synced_nxt = 1'b0;
    end else begin
      if (shift_seen_r) begin
        shift_seen_nxt = 1'b0;
        if (ones_r != afzc_pkg::STUFF_RUN) begin
          sbyte_nxt = {1'b0, sbyte_r[7:1]};
          tally_nxt = tally_r + 8'd1;
          shifted   = 1'b1;
        end
        cd_nxt   = afzc_pkg::CD_SHIFT;
        ones_nxt = 3'd0;
      end else if (cd_r <= afzc_pkg::CdW'(1)) begin
        sbyte_nxt = {1'b1, sbyte_r[7:1]};
        tally_nxt = tally_r + 8'd1;
        shifted   = 1'b1;
        cd_nxt    = afzc_pkg::CD_BIT;
        if (ones_r < afzc_pkg::ONES_MAX) begin
          ones_nxt = ones_r + 3'd1;
        end
      end else begin
        cd_nxt = cd_r - afzc_pkg::CdW'(1);
      end

      if (shifted) begin
        if (sbyte_nxt == afzc_pkg::FLAG_BYTE) begin
          tally_nxt  = afzc_pkg::TALLY_FULL;
          synced_nxt = 1'b1;
        end
        if (synced_nxt && tally_nxt >= afzc_pkg::TALLY_FULL) begin
          emit      = 1'b1;
          tally_nxt = 8'd0;
        end else if (tally_nxt > afzc_pkg::TALLY_LIMIT) begin
          tally_nxt = afzc_pkg::TALLY_FULL;
        end
      end
    end

    res_item.byte_valid   = emit;
    res_item.data_byte    = emit ? sbyte_nxt : 8'd0;
    res_item.carrier_tone = tone_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r       <= afzc_pkg::TONE_NONE;
      shift_seen_r <= 1'b0;
      hold_r       <= 8'd0;
      sbyte_r      <= 8'd0;
      tally_r      <= 8'd0;
      ones_r       <= 3'd0;
      cd_r         <= afzc_pkg::CD_BIT;
      synced_r     <= 1'b0;
    end else if (cmd_take) begin
      tone_r       <= tone_nxt;
      shift_seen_r <= shift_seen_nxt;
      hold_r       <= hold_nxt;
      sbyte_r      <= sbyte_nxt;
      tally_r      <= tally_nxt;
      ones_r       <= ones_nxt;
      cd_r         <= cd_nxt;
      synced_r     <= synced_nxt;
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cmd_take) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({cmd_take, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      q_r[wr_ptr_r] <= res_item;
    end
  end

  a_edge_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_take && !cmd.is_tick) |-> !res_item.byte_valid)
    else $error("edge beat produced a byte");

  a_drop_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_take && cmd.is_tick && tone_r == afzc_pkg::TONE_NONE) |=> !synced_r)
    else $error("sync kept without carrier");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_take && emit) |=> (tally_r == 8'd0 && synced_r))
    else $error("byte emitted without tally reset");

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result queue count overflow");

endmodule

// File: sv/afsk_zero_cross_nrzi_decoder.sv
// Channel  Handshake          Payload                      Direction
// input    in_push / in_full  in_data  (operation, period)  in
// result   out_pop / out_empty out_data (byte, tone)        out
// config   cfg_we             cfg_addr, cfg_wdata           in
//
// One item per cycle sustained while out_pop keeps up; each item yields one result beat.
// A beat is registered in the command queue, then in the result queue, to reach out_data.
// Front classifies periods against the bands into a 2-deep command queue;
// back runs the carrier/NRZI/flag state and fills a 2-deep result queue.
// Reset (rst_n low, synchronous) loads band and hold defaults and empties both queues.
// A stalled out_pop backs up result queue, then command queue, then in_full.
module afsk_zero_cross_nrzi_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  afzc_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output afzc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata
);

  afzc_pkg::cfg_t cfg_r;
  afzc_pkg::cmd_t cmd;
  logic           cmd_avail;
  logic           cmd_take;

  // Configuration registers; writes past the last index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_high_min <= afzc_pkg::RST_BAND_HIGH_MIN;
      cfg_r.band_high_max <= afzc_pkg::RST_BAND_HIGH_MAX;
      cfg_r.band_low_min  <= afzc_pkg::RST_BAND_LOW_MIN;
      cfg_r.band_low_max  <= afzc_pkg::RST_BAND_LOW_MAX;
      cfg_r.carrier_hold  <= afzc_pkg::RST_CARRIER_HOLD;
    end else if (cfg_we) begin
      case (cfg_addr)
        afzc_pkg::REG_BAND_HIGH_MIN: cfg_r.band_high_min <= cfg_wdata;
        afzc_pkg::REG_BAND_HIGH_MAX: cfg_r.band_high_max <= cfg_wdata;
        afzc_pkg::REG_BAND_LOW_MIN:  cfg_r.band_low_min  <= cfg_wdata;
        afzc_pkg::REG_BAND_LOW_MAX:  cfg_r.band_low_max  <= cfg_wdata;
        afzc_pkg::REG_CARRIER_HOLD:  cfg_r.carrier_hold  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Front: period classification and command queue.
  afzc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (in_push),
    .full      (in_full),
    .item      (in_data),
    .cmd_avail (cmd_avail),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // Back: carrier tracking, bit recovery, flag sync, result queue.
  afzc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .carrier_hold (cfg_r.carrier_hold),
    .cmd_avail    (cmd_avail),
    .cmd_take     (cmd_take),
    .cmd          (cmd),
    .res_empty    (out_empty),
    .res_pop      (out_pop),
    .res          (out_data)
  );

endmodule

// File: dv/tb_afsk_zero_cross_nrzi_decoder.sv
`timescale 1ns / 1ps

module tb_afsk_zero_cross_nrzi_decoder;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;   // idle clocks before the final report

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  afzc_pkg::in_item_t  in_data = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  afzc_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_addr = '0;
  logic [15:0]         cfg_wdata = '0;

  afsk_zero_cross_nrzi_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Edge/tick events waiting for the driver, and decoded beats the DUT owes us.
  afzc_pkg::in_item_t  afsk_events[$];
  afzc_pkg::out_item_t decoded_beats[$];
  afzc_pkg::out_item_t head_beat;
  int                  mismatches = 0;
  int                  cycle_count = 0;

  // Mirror of the band/hold registers, kept in step with every cfg write.
  afzc_pkg::cfg_t bands = '{band_high_min: afzc_pkg::RST_BAND_HIGH_MIN,
                            band_high_max: afzc_pkg::RST_BAND_HIGH_MAX,
                            band_low_min: afzc_pkg::RST_BAND_LOW_MIN,
                            band_low_max: afzc_pkg::RST_BAND_LOW_MAX,
                            carrier_hold: afzc_pkg::RST_CARRIER_HOLD};

  // Demodulator state mirror
  logic [1:0]               dm_tone   = afzc_pkg::TONE_NONE;
  logic                     dm_shift  = 1'b0;
  logic [7:0]               dm_hold   = '0;
  logic [7:0]               dm_sreg   = '0;
  logic [7:0]               dm_tally  = '0;
  logic [2:0]               dm_ones   = '0;
  logic [afzc_pkg::CdW-1:0] dm_cd     = afzc_pkg::CD_BIT;
  logic                     dm_synced = 1'b0;

  // Sender-side NRZI state for building frames
  logic [1:0] tx_tone = afzc_pkg::TONE_1200;
  int         tx_ones = 0;

  // ---------------------------------------------------------------------
  // Predictor: one decoded beat per accepted event
  // ---------------------------------------------------------------------
  function automatic void demodulate(afzc_pkg::in_item_t ev);
    afzc_pkg::out_item_t beat;
    logic [1:0]          tone;
    logic                moved;
    beat  = '0;
    moved = 1'b0;
    if (ev.operation == afzc_pkg::OP_EDGE) begin
      // 1200 Hz band checked first, so it wins where bands overlap
      if (ev.edge_period > bands.band_low_min && ev.edge_period < bands.band_low_max)
        tone = afzc_pkg::TONE_1200;
      else if (ev.edge_period > bands.band_high_min &&
               ev.edge_period < bands.band_high_max)
        tone = afzc_pkg::TONE_2200;
      else
        tone = afzc_pkg::TONE_NONE;
      if (tone != afzc_pkg::TONE_NONE) begin
        if (dm_tone != tone) dm_shift = 1'b1;   // includes acquiring from none
        dm_tone = tone;
        dm_hold = bands.carrier_hold;
      end else if (dm_hold != 0) begin
        dm_hold = dm_hold - 8'd1;
      end else begin
        dm_tone = afzc_pkg::TONE_NONE;
      end
    end else if (dm_tone == afzc_pkg::TONE_NONE) begin
      dm_synced = 1'b0;
    end else begin
      if (dm_shift) begin
        dm_shift = 1'b0;
        if (dm_ones != afzc_pkg::STUFF_RUN) begin   // zero after five ones is stuffing
          dm_sreg  = dm_sreg >> 1;
          dm_tally = dm_tally + 8'd1;
          moved    = 1'b1;
        end
        dm_cd   = afzc_pkg::CD_SHIFT;
        dm_ones = '0;
      end else if (dm_cd <= 1) begin
        dm_sreg  = {1'b1, dm_sreg[7:1]};
        dm_tally = dm_tally + 8'd1;
        moved    = 1'b1;
        dm_cd    = afzc_pkg::CD_BIT;
        if (dm_ones < afzc_pkg::ONES_MAX) dm_ones = dm_ones + 3'd1;
      end else begin
        dm_cd = dm_cd - afzc_pkg::CdW'(1);
      end
      // flag match and byte output only on ticks that moved a bit in
      if (moved) begin
        if (dm_sreg == afzc_pkg::FLAG_BYTE) begin
          dm_tally  = afzc_pkg::TALLY_FULL;
          dm_synced = 1'b1;
        end
        if (dm_synced && dm_tally >= afzc_pkg::TALLY_FULL) begin
          beat.byte_valid = 1'b1;
          beat.data_byte  = dm_sreg;
          dm_tally        = '0;
        end else if (dm_tally > afzc_pkg::TALLY_LIMIT) begin
          dm_tally = afzc_pkg::TALLY_FULL;
        end
      end
    end
    beat.carrier_tone = dm_tone;
    decoded_beats.push_back(beat);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic void add_edge(logic [15:0] period);
    afzc_pkg::in_item_t ev;
    ev.operation   = afzc_pkg::OP_EDGE;
    ev.edge_period = period;
    afsk_events.push_back(ev);
  endfunction

  function automatic void add_tick();
    afzc_pkg::in_item_t ev;
    ev.operation   = afzc_pkg::OP_TICK;
    ev.edge_period = 16'($urandom);   // ignored on ticks, randomized anyway
    afsk_events.push_back(ev);
  endfunction

  // Period strictly inside the band of the given tone; for 2200 Hz, steer
  // clear of an overlapping 1200 Hz band. Empty band: anything goes.
  function automatic logic [15:0] tone_period(logic [1:0] tone);
    int          lo;
    int          hi;
    logic [15:0] p;
    if (tone == afzc_pkg::TONE_1200) begin
      lo = bands.band_low_min;
      hi = bands.band_low_max;
    end else begin
      lo = bands.band_high_min;
      hi = bands.band_high_max;
    end
    if (hi - lo < 2) return 16'($urandom);
    p = 16'($urandom_range(lo + 1, hi - 1));
    if (tone == afzc_pkg::TONE_2200)
      for (int k = 0; k < 8 && p > bands.band_low_min && p < bands.band_low_max; k++)
        p = 16'($urandom_range(lo + 1, hi - 1));
    return p;
  endfunction

  function automatic logic [15:0] random_period();
    case ($urandom_range(0, 5))
      0: return tone_period(afzc_pkg::TONE_1200);
      1: return tone_period(afzc_pkg::TONE_2200);
      2: begin
        // band edges: exclusive bounds and the first value inside
        case ($urandom_range(0, 3))
          0: return bands.band_low_min + 16'($urandom_range(0, 1));
          1: return bands.band_low_max - 16'($urandom_range(0, 1));
          2: return bands.band_high_min + 16'($urandom_range(0, 1));
          default: return bands.band_high_max - 16'($urandom_range(0, 1));
        endcase
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void noise_burst(int n);
    repeat (n) begin
      if ($urandom_range(0, 1)) add_tick();
      else add_edge(random_period());
    end
  endfunction

  // NRZI: a zero is a tone change, a one is a bit time with no change.
  // Same-tone edges sprinkled in keep the carrier hold topped up.
  function automatic void send_bit(logic b);
    if (!b) begin
      tx_tone = (tx_tone == afzc_pkg::TONE_1200) ? afzc_pkg::TONE_2200 :
                                                   afzc_pkg::TONE_1200;
      add_edge(tone_period(tx_tone));
    end
    for (int t = 0; t < afzc_pkg::TicksPerBit; t++) begin
      if ($urandom_range(0, 99) < 15) add_edge(tone_period(tx_tone));
      add_tick();
    end
  endfunction

  function automatic void send_byte(logic [7:0] v, logic stuffed);
    for (int i = 0; i < 8; i++) begin
      send_bit(v[i]);
      if (stuffed) begin
        tx_ones = v[i] ? tx_ones + 1 : 0;
        if (tx_ones == 5) begin
          send_bit(1'b0);
          tx_ones = 0;
        end
      end
    end
    if (!stuffed) tx_ones = 0;
  endfunction

  // Flag(s), a couple of stuffed data bytes, usually a closing flag.
  // Some frames get noise dropped in the middle.
  function automatic void send_frame();
    logic [7:0] v;
    add_edge(tone_period(tx_tone));
    tx_ones = 0;
    repeat ($urandom_range(1, 2)) send_byte(afzc_pkg::FLAG_BYTE, 1'b0);
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 7))
        0, 1: v = 8'hFF;                // forces stuffing and long one runs
        2: v = afzc_pkg::FLAG_BYTE;     // flag pattern in data, broken by stuffing
        default: v = 8'($urandom);
      endcase
      send_byte(v, 1'b1);
      if ($urandom_range(0, 99) < 15) noise_burst($urandom_range(3, 10));
    end
    if ($urandom_range(0, 3) != 0) send_byte(afzc_pkg::FLAG_BYTE, 1'b0);
  endfunction

  function automatic void fill_until(int target);
    while (afsk_events.size() < target) begin
      if ($urandom_range(0, 9) < 6) send_frame();
      else noise_burst($urandom_range(5, 40));
    end
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------
  // Config writes: only with nothing in flight
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      afzc_pkg::REG_BAND_HIGH_MIN: bands.band_high_min = val;
      afzc_pkg::REG_BAND_HIGH_MAX: bands.band_high_max = val;
      afzc_pkg::REG_BAND_LOW_MIN:  bands.band_low_min  = val;
      afzc_pkg::REG_BAND_LOW_MAX:  bands.band_low_max  = val;
      afzc_pkg::REG_CARRIER_HOLD:  bands.carrier_hold  = val[7:0];
      default: ;   // unmapped index, DUT must ignore
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_bands(logic [15:0] hmin, logic [15:0] hmax,
                             logic [15:0] lmin, logic [15:0] lmax, logic [15:0] hold);
    write_reg(afzc_pkg::REG_BAND_HIGH_MIN, hmin);
    write_reg(afzc_pkg::REG_BAND_HIGH_MAX, hmax);
    write_reg(afzc_pkg::REG_BAND_LOW_MIN, lmin);
    write_reg(afzc_pkg::REG_BAND_LOW_MAX, lmax);
    write_reg(afzc_pkg::REG_CARRIER_HOLD, hold);
    end_writes();
  endtask

  // Sender holds off here until every owed beat has come back
  task automatic wait_drained();
    @(negedge clk);
    while (afsk_events.size() != 0 || in_push || decoded_beats.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: push side, random gaps with occasional gap-free runs
  // ---------------------------------------------------------------------
  int tx_wait = 0;
  int tx_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) demodulate(in_data);
      if (!in_push || !in_full) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_push <= 1'b0;
        end else if (afsk_events.size() != 0) begin
          in_data <= afsk_events.pop_front();
          in_push <= 1'b1;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            if ($urandom_range(0, 99) < 4) tx_calm = $urandom_range(20, 80);
            tx_wait = pause_len();
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: pop side with random stalls, field-by-field compare
  // ---------------------------------------------------------------------
  int rx_hold = 0;
  int rx_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (decoded_beats.size() == 0) begin
          $error("unexpected result beat: %p", out_data);
          mismatches++;
        end else begin
          head_beat = decoded_beats.pop_front();
          if (out_data.byte_valid !== head_beat.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d",
                   head_beat.byte_valid, out_data.byte_valid);
            mismatches++;
          end
          if (out_data.data_byte !== head_beat.data_byte) begin
            $error("data_byte: expected 0x%02h, got 0x%02h",
                   head_beat.data_byte, out_data.data_byte);
            mismatches++;
          end
          if (out_data.carrier_tone !== head_beat.carrier_tone) begin
            $error("carrier_tone: expected %0d, got %0d",
                   head_beat.carrier_tone, out_data.carrier_tone);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          if ($urandom_range(0, 99) < 4) rx_calm = $urandom_range(20, 80);
          rx_hold = pause_len();
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed events, then config phases with random traffic
  // ---------------------------------------------------------------------
  initial begin
    int lo;
    int hi;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Short hold so carrier loss shows up within a few edges
    write_reg(afzc_pkg::REG_CARRIER_HOLD, 16'd2);
    end_writes();
    add_tick();                 // tick with no carrier
    add_edge(16'd0);
    add_edge(16'hFFFF);
    add_edge(16'd800);          // exclusive band bounds: all invalid
    add_edge(16'd877);
    add_edge(16'd1417);
    add_edge(16'd1675);
    add_edge(16'd801);          // carrier acquired from none -> shift
    add_tick();
    add_edge(16'd876);          // same tone, no shift
    add_edge(16'd1418);         // tone change
    add_edge(16'd1674);
    add_tick();
    add_tick();
    add_edge(16'd1);            // hold counts down ...
    add_edge(16'hFFFF);
    add_edge(16'd2000);         // ... and carrier drops
    add_tick();
    add_edge(16'd1500);
    add_tick();
    add_edge(16'd850);
    add_tick();
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          // hold 0: one bad edge kills carrier, which clears sync; then a long
          // run of zeros keeps the bit count climbing past its wrap limit
          write_bands(afzc_pkg::RST_BAND_HIGH_MIN, afzc_pkg::RST_BAND_HIGH_MAX,
                      afzc_pkg::RST_BAND_LOW_MIN, afzc_pkg::RST_BAND_LOW_MAX, 16'd0);
          add_edge(tone_period(tx_tone));
          add_edge(16'd0);
          add_tick();
          repeat (256) begin
            tx_tone = (tx_tone == afzc_pkg::TONE_1200) ? afzc_pkg::TONE_2200 :
                                                         afzc_pkg::TONE_1200;
            add_edge(tone_period(tx_tone));
            add_tick();
          end
        end
        1: begin
          write_bands(afzc_pkg::RST_BAND_HIGH_MIN, afzc_pkg::RST_BAND_HIGH_MAX,
                      afzc_pkg::RST_BAND_LOW_MIN, afzc_pkg::RST_BAND_LOW_MAX,
                      16'(afzc_pkg::RST_CARRIER_HOLD));
          fill_until(150);
        end
        2: begin
          write_bands(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);   // nothing is a tone
          noise_burst(50);
        end
        3: begin
          write_bands(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          // unmapped indexes must leave every register alone
          for (int a = afzc_pkg::REG_CARRIER_HOLD + 1; a < 8; a++)
            write_reg(3'(a), 16'($urandom));
          end_writes();
          noise_burst(50);
        end
        4: begin
          // overlapping bands: 1200 Hz must win in the overlap
          write_bands(16'd700, 16'd1500, 16'd1300, 16'd1700, 16'd255);
          fill_until(80);
        end
        5: begin
          lo = $urandom_range(0, 60000);
          hi = $urandom_range(0, 60000);
          write_bands(16'(hi), 16'((hi + $urandom_range(2, 4000)) > 65535 ? 65535 :
                                   hi + $urandom_range(2, 4000)),
                      16'(lo), 16'((lo + $urandom_range(2, 4000)) > 65535 ? 65535 :
                                   lo + $urandom_range(2, 4000)),
                      16'($urandom));
          fill_until(40);
        end
        default: begin
          write_bands(afzc_pkg::RST_BAND_HIGH_MIN, afzc_pkg::RST_BAND_HIGH_MAX,
                      afzc_pkg::RST_BAND_LOW_MIN, afzc_pkg::RST_BAND_LOW_MAX,
                      16'($urandom_range(1, 6)));
          fill_until(40);
        end
      endcase
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
